FILE: hdl/assert_macros.svh
// Assertion macros shared by the blit address generator modules.
// Needs nothing else; each file that asserts includes it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never hold outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed: condition must never hold");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: hdl/cbrag_pkg.sv
// Shared types and constants of the clipped blit row address generator.
// No dependencies; imported by every module of the block.
`default_nettype none

package cbrag_pkg;

  localparam int MAX_SIDE           = 1024;
  localparam int ADDR_BITS_DEFAULT  = 24;
  localparam int QUEUE_DEPTH        = 4;
  localparam int DIM_W              = 11;
  localparam int BASE_W             = 24;
  localparam int OUT_ADDR_W         = 24;
  localparam int COORD_W            = 12;
  localparam int CLIP_W             = 14;
  localparam int PROD_W             = 2 * DIM_W;
  localparam int APB_AW             = 5;
  localparam int APB_DW             = 32;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_ROW   = 1'b1;

  typedef enum logic [2:0] {
    REG_SOURCE_WIDTH  = 3'd0,
    REG_SOURCE_HEIGHT = 3'd1,
    REG_TARGET_WIDTH  = 3'd2,
    REG_TARGET_HEIGHT = 3'd3,
    REG_SOURCE_BASE   = 3'd4,
    REG_TARGET_BASE   = 3'd5
  } reg_idx_t;

  typedef logic [DIM_W-1:0] dim_t;

  // Image dimensions already clamped to MAX_SIDE.
  typedef struct packed {
    dim_t              sw;
    dim_t              sh;
    dim_t              tw;
    dim_t              th;
    logic [BASE_W-1:0] sbase;
    logic [BASE_W-1:0] tbase;
  } cfg_t;

  typedef struct packed {
    logic req;
    logic nonempty;
    dim_t width;
    dim_t rows;
  } cmd_t;

endpackage

`default_nettype wire

FILE: hdl/cbrag_cfg.sv
// Configuration registers with APB-style access and dimension clamping.
// Depends on cbrag_pkg.
`default_nettype none

module cbrag_cfg
  import cbrag_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  localparam int CmpW = DIM_W + 2;

  dim_t              source_width;
  dim_t              source_height;
  dim_t              target_width;
  dim_t              target_height;
  logic [BASE_W-1:0] source_base;
  logic [BASE_W-1:0] target_base;
  reg_idx_t          idx;
  logic              wr;

  function automatic dim_t dim_clamp(input dim_t v);
    return ({2'b00, v} > CmpW'(MAX_SIDE)) ? DIM_W'(MAX_SIDE) : v;
  endfunction

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= DIM_W'(320);
      source_height <= DIM_W'(200);
      target_width  <= DIM_W'(320);
      target_height <= DIM_W'(200);
      source_base   <= '0;
      target_base   <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_SOURCE_WIDTH:  source_width  <= pwdata[DIM_W-1:0];
        REG_SOURCE_HEIGHT: source_height <= pwdata[DIM_W-1:0];
        REG_TARGET_WIDTH:  target_width  <= pwdata[DIM_W-1:0];
        REG_TARGET_HEIGHT: target_height <= pwdata[DIM_W-1:0];
        REG_SOURCE_BASE:   source_base   <= pwdata[BASE_W-1:0];
        REG_TARGET_BASE:   target_base   <= pwdata[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SOURCE_WIDTH:  prdata = APB_DW'(source_width);
      REG_SOURCE_HEIGHT: prdata = APB_DW'(source_height);
      REG_TARGET_WIDTH:  prdata = APB_DW'(target_width);
      REG_TARGET_HEIGHT: prdata = APB_DW'(target_height);
      REG_SOURCE_BASE:   prdata = APB_DW'(source_base);
      REG_TARGET_BASE:   prdata = APB_DW'(target_base);
      default:           prdata = '0;
    endcase
  end

  always_comb begin
    cfg.sw    = dim_clamp(source_width);
    cfg.sh    = dim_clamp(source_height);
    cfg.tw    = dim_clamp(target_width);
    cfg.th    = dim_clamp(target_height);
    cfg.sbase = source_base;
    cfg.tbase = target_base;
  end

endmodule

`default_nettype wire

FILE: hdl/cbrag_front.sv
// Front end: accepts requests, clips start rectangles and forms first-row
// addresses in a three-stage elastic pipeline. Depends on cbrag_pkg.
`default_nettype none
`include "assert_macros.svh"

module cbrag_front
  import cbrag_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire cfg_t                       cfg,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       req_type,
  input  wire logic signed [COORD_W-1:0]  rect_x,
  input  wire logic signed [COORD_W-1:0]  rect_y,
  input  wire logic        [DIM_W-1:0]    rect_w,
  input  wire logic        [DIM_W-1:0]    rect_h,
  input  wire logic signed [COORD_W-1:0]  pos_x,
  input  wire logic signed [COORD_W-1:0]  pos_y,
  output logic                            cmd_valid,
  input  wire logic                       cmd_ready,
  output cmd_t                            cmd,
  output logic             [ADDR_BITS-1:0] cmd_src,
  output logic             [ADDR_BITS-1:0] cmd_dst
);

  typedef logic signed [CLIP_W-1:0] coord_t;

  typedef struct packed {
    coord_t lo;
    coord_t len;
  } span_t;

  // Clip [lo, lo+len) to [0, side); empty overlap gives zero length.
  function automatic span_t clip1(input coord_t lo, input coord_t len, input coord_t side);
    coord_t a;
    coord_t b;
    span_t  s;
    a = (lo > coord_t'(0)) ? lo : coord_t'(0);
    b = ((lo + len) < side) ? (lo + len) : side;
    s.lo  = a;
    s.len = (b > a) ? (b - a) : coord_t'(0);
    return s;
  endfunction

  function automatic coord_t uext(input dim_t v);
    return coord_t'({{(CLIP_W-DIM_W){1'b0}}, v});
  endfunction

  logic adv1, adv2, adv3;
  logic v1, v2, v3;
  logic stall3;

  logic   s1_req;
  span_t  s1_sx, s1_sy;
  coord_t s1_offx, s1_offy;

  logic   s2_req;
  span_t  s2_dx, s2_dy;
  coord_t s2_offx, s2_offy;

  logic              s3_req;
  logic              s3_empty;
  logic [PROD_W-1:0] s3_prod_s, s3_prod_d;
  dim_t              s3_srcx, s3_dxo, s3_width, s3_rows;

  coord_t srcx, srcy;

  assign adv3     = !v3 || cmd_ready;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;
  assign stall3   = v3 && !cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= in_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
      if (adv3) begin
        v3 <= v2;
      end
    end
  end

  // Stage 1: clip to source image, offset source to target.
  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_req  <= req_type;
      s1_sx   <= clip1(coord_t'(rect_x), uext(rect_w), uext(cfg.sw));
      s1_sy   <= clip1(coord_t'(rect_y), uext(rect_h), uext(cfg.sh));
      s1_offx <= coord_t'(pos_x) - coord_t'(rect_x);
      s1_offy <= coord_t'(pos_y) - coord_t'(rect_y);
    end
  end

  // Stage 2: clip to target image.
  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_req  <= s1_req;
      s2_dx   <= clip1(s1_sx.lo + s1_offx, s1_sx.len, uext(cfg.tw));
      s2_dy   <= clip1(s1_sy.lo + s1_offy, s1_sy.len, uext(cfg.th));
      s2_offx <= s1_offx;
      s2_offy <= s1_offy;
    end
  end

  // Stage 3: back to source coordinates, row stride products.
  always_comb begin
    srcx = s2_dx.lo - s2_offx;
    srcy = s2_dy.lo - s2_offy;
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_req    <= s2_req;
      s3_empty  <= (s2_dx.len == coord_t'(0)) || (s2_dy.len == coord_t'(0));
      s3_prod_s <= srcy[DIM_W-1:0] * cfg.sw;
      s3_prod_d <= s2_dy.lo[DIM_W-1:0] * cfg.tw;
      s3_srcx   <= srcx[DIM_W-1:0];
      s3_dxo    <= s2_dx.lo[DIM_W-1:0];
      s3_width  <= s2_dx.len[DIM_W-1:0];
      s3_rows   <= s2_dy.len[DIM_W-1:0];
    end
  end

  always_comb begin
    cmd_valid    = v3;
    cmd.req      = s3_req;
    cmd.nonempty = !s3_empty;
    cmd.width    = s3_empty ? '0 : s3_width;
    cmd.rows     = s3_empty ? '0 : s3_rows;
    cmd_src      = s3_empty ? '0 : ADDR_BITS'(cfg.sbase) + ADDR_BITS'(s3_prod_s)
                                 + ADDR_BITS'(s3_srcx);
    cmd_dst      = s3_empty ? '0 : ADDR_BITS'(cfg.tbase) + ADDR_BITS'(s3_prod_d)
                                 + ADDR_BITS'(s3_dxo);
  end

  `ASSERT_NEXT(a_stall_holds, clk, rst, stall3, v3 && $stable(s3_prod_s) && $stable(s3_rows))

endmodule

`default_nettype wire

FILE: hdl/cbrag_queue.sv
// Small register FIFO between front and back ends, first-word fall-through.
// Depends on cbrag_pkg.
`default_nettype none
`include "assert_macros.svh"

module cbrag_queue
  import cbrag_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  wr_ready,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  rd_valid
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr, rd_ptr;
  logic [CntW-1:0]  count;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign wr_ready = (count != CntW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (rd_en) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (wr_en && !rd_en) begin
        count <= count + CntW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk, rst, wr_en && !wr_ready)
  `ASSERT_NEVER(a_no_underflow, clk, rst, rd_en && !rd_valid)

endmodule

`default_nettype wire

FILE: hdl/cbrag_back.sv
// Back end: holds the blit walk state and issues one result per command
// into the output register. Depends on cbrag_pkg.
`default_nettype none
`include "assert_macros.svh"

module cbrag_back
  import cbrag_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cfg_t                   cfg,
  input  wire logic                   cmd_valid,
  output logic                        cmd_ready,
  input  wire cmd_t                   cmd,
  input  wire logic [ADDR_BITS-1:0]   cmd_src,
  input  wire logic [ADDR_BITS-1:0]   cmd_dst,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [OUT_ADDR_W-1:0]       src_addr,
  output logic [OUT_ADDR_W-1:0]       dst_addr,
  output logic [DIM_W-1:0]            row_len,
  output logic [DIM_W-1:0]            row_count,
  output logic                        row_valid,
  output logic                        last_row
);

  logic [ADDR_BITS-1:0] next_src_row, next_dst_row;
  dim_t                 clipped_width, rows_remaining;
  logic                 pop;
  logic                 active;
  logic                 out_zero;

  assign cmd_ready = !out_valid || out_ready;
  assign pop       = cmd_valid && cmd_ready;
  assign active    = (rows_remaining != '0);
  assign out_zero  = (row_len == '0) && (row_count == '0) && (src_addr == '0)
                     && (dst_addr == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      next_src_row   <= '0;
      next_dst_row   <= '0;
      clipped_width  <= '0;
      rows_remaining <= '0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        unique case (cmd.req)
          REQ_START: begin
            next_src_row   <= cmd_src;
            next_dst_row   <= cmd_dst;
            clipped_width  <= cmd.width;
            rows_remaining <= cmd.rows;
          end
          REQ_ROW: begin
            if (active) begin
              next_src_row   <= next_src_row + ADDR_BITS'(cfg.sw);
              next_dst_row   <= next_dst_row + ADDR_BITS'(cfg.tw);
              rows_remaining <= rows_remaining - DIM_W'(1);
            end
          end
        endcase
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      unique case (cmd.req)
        REQ_START: begin
          src_addr  <= OUT_ADDR_W'(cmd_src);
          dst_addr  <= OUT_ADDR_W'(cmd_dst);
          row_len   <= cmd.width;
          row_count <= cmd.rows;
          row_valid <= cmd.nonempty;
          last_row  <= 1'b0;
        end
        REQ_ROW: begin
          src_addr  <= active ? OUT_ADDR_W'(next_src_row) : '0;
          dst_addr  <= active ? OUT_ADDR_W'(next_dst_row) : '0;
          row_len   <= active ? clipped_width : '0;
          row_count <= '0;
          row_valid <= active;
          last_row  <= (rows_remaining == DIM_W'(1));
        end
      endcase
    end
  end

  `ASSERT_IMPLIES(a_last_ends_walk, clk, rst, out_valid && last_row, rows_remaining == '0)
  `ASSERT_IMPLIES(a_empty_is_zero, clk, rst, out_valid && !row_valid, out_zero)
  `ASSERT_IMPLIES(a_count_on_start, clk, rst, out_valid && row_count != '0, row_valid && !last_row)

endmodule

`default_nettype wire

FILE: hdl/clipped_blit_row_address_generator.sv
// Top level of the clipped blit row address generator.
// Depends on cbrag_pkg, cbrag_cfg, cbrag_front, cbrag_queue and cbrag_back.
//
// Usage: program image sizes and base addresses over the APB port while idle
// (pready is always high, a write lands on the access cycle). Requests enter
// on in_valid/in_ready: req_type start carries the source rectangle and the
// target position; req_type row asks for the next row of the current blit.
// Every request gives exactly one result on out_valid/out_ready: a start
// returns the clipped width, the row count, the first row addresses and
// whether anything is left; each row request returns one row's source and
// target addresses, length and last-row flag, or all zeros when no blit runs.
// After its input transfer a request passes three clip/multiply pipeline
// stages, one queue slot and one output register before its result shows.
// Throughput: one request per cycle while out_ready stays high, set by the
// one-row-per-cycle update of the walk registers in the back end.
// When the receiver stalls, the output register holds its result, the queue
// fills and the front pipeline backs up until in_ready falls.
// Reset (synchronous, rst high) restores the default registers, empties the
// pipeline and the queue, and leaves no blit active.
`default_nettype none

module clipped_blit_row_address_generator
  import cbrag_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [APB_AW-1:0]         paddr,
  input  wire logic [APB_DW-1:0]         pwdata,
  output logic      [APB_DW-1:0]         prdata,
  output logic                           pready,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      req_type,
  input  wire logic signed [COORD_W-1:0] rect_x,
  input  wire logic signed [COORD_W-1:0] rect_y,
  input  wire logic        [DIM_W-1:0]   rect_w,
  input  wire logic        [DIM_W-1:0]   rect_h,
  input  wire logic signed [COORD_W-1:0] pos_x,
  input  wire logic signed [COORD_W-1:0] pos_y,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [OUT_ADDR_W-1:0]          src_addr,
  output logic [OUT_ADDR_W-1:0]          dst_addr,
  output logic [DIM_W-1:0]               row_len,
  output logic [DIM_W-1:0]               row_count,
  output logic                           row_valid,
  output logic                           last_row
);

  localparam int QW = $bits(cmd_t) + 2 * ADDR_BITS;

  cfg_t                 cfg;
  cmd_t                 f_cmd, b_cmd;
  logic [ADDR_BITS-1:0] f_src, f_dst, b_src, b_dst;
  logic                 f_valid, f_ready;
  logic                 b_valid, b_ready;
  logic [QW-1:0]        q_rd_data;

  cbrag_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cbrag_front #(
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .rect_x    (rect_x),
    .rect_y    (rect_y),
    .rect_w    (rect_w),
    .rect_h    (rect_h),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd),
    .cmd_src   (f_src),
    .cmd_dst   (f_dst)
  );

  cbrag_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (f_valid && f_ready),
    .wr_data  ({f_cmd, f_src, f_dst}),
    .wr_ready (f_ready),
    .rd_en    (b_valid && b_ready),
    .rd_data  (q_rd_data),
    .rd_valid (b_valid)
  );

  assign {b_cmd, b_src, b_dst} = q_rd_data;

  cbrag_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (b_valid),
    .cmd_ready (b_ready),
    .cmd       (b_cmd),
    .cmd_src   (b_src),
    .cmd_dst   (b_dst),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .src_addr  (src_addr),
    .dst_addr  (dst_addr),
    .row_len   (row_len),
    .row_count (row_count),
    .row_valid (row_valid),
    .last_row  (last_row)
  );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for clipped_blit_row_address_generator.
// Depends on cbrag_pkg and the block's RTL; an in-bench predictor clips each
// start rectangle and walks the rows, and every result transfer is checked.
`timescale 1ns / 100ps

module tb_top
  import cbrag_pkg::*;
;

  localparam int unsigned UNUSED_REG_A = 6;
  localparam int unsigned UNUSED_REG_B = 7;

  typedef struct {
    logic                      req_type;
    logic signed [COORD_W-1:0] rect_x;
    logic signed [COORD_W-1:0] rect_y;
    dim_t                      rect_w;
    dim_t                      rect_h;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
  } blit_req_t;

  typedef struct {
    logic [OUT_ADDR_W-1:0] src_addr;
    logic [OUT_ADDR_W-1:0] dst_addr;
    dim_t                  row_len;
    dim_t                  row_count;
    logic                  row_valid;
    logic                  last_row;
  } row_descr_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [APB_AW-1:0]         paddr = '0;
  logic [APB_DW-1:0]         pwdata = '0;
  logic [APB_DW-1:0]         prdata;
  logic                      pready;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      req_type = REQ_START;
  logic signed [COORD_W-1:0] rect_x = '0;
  logic signed [COORD_W-1:0] rect_y = '0;
  logic        [DIM_W-1:0]   rect_w = '0;
  logic        [DIM_W-1:0]   rect_h = '0;
  logic signed [COORD_W-1:0] pos_x = '0;
  logic signed [COORD_W-1:0] pos_y = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [OUT_ADDR_W-1:0]     src_addr;
  logic [OUT_ADDR_W-1:0]     dst_addr;
  logic [DIM_W-1:0]          row_len;
  logic [DIM_W-1:0]          row_count;
  logic                      row_valid;
  logic                      last_row;

  // predictor copy of the registers and the row walk
  dim_t              img_src_w = 11'd320;
  dim_t              img_src_h = 11'd200;
  dim_t              img_dst_w = 11'd320;
  dim_t              img_dst_h = 11'd200;
  logic [BASE_W-1:0] img_src_base = '0;
  logic [BASE_W-1:0] img_dst_base = '0;
  logic [23:0]       walk_src = '0;
  logic [23:0]       walk_dst = '0;
  dim_t              walk_width = '0;
  dim_t              walk_rows_left = '0;

  row_descr_t expected_rows[$];
  int         error_count = 0;
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  int         hold_left = 0;

  clipped_blit_row_address_generator uut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .rect_x    (rect_x),
    .rect_y    (rect_y),
    .rect_w    (rect_w),
    .rect_h    (rect_h),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .src_addr  (src_addr),
    .dst_addr  (dst_addr),
    .row_len   (row_len),
    .row_count (row_count),
    .row_valid (row_valid),
    .last_row  (last_row)
  );

  always #4 clk = ~clk;

  function automatic int clamp_side(dim_t v);
    return (v > MAX_SIDE) ? MAX_SIDE : int'(v);
  endfunction

  // clip [lo, lo+len) to [0, side); empty overlap gives zero length
  function automatic void clip_span(input int lo, input int len, input int side,
                                    output int olo, output int olen);
    int hi;
    olo = (lo > 0) ? lo : 0;
    hi = (lo + len < side) ? lo + len : side;
    olen = (hi > olo) ? hi - olo : 0;
  endfunction

  function automatic row_descr_t predict_descriptor(blit_req_t r);
    row_descr_t d;
    int sw, sh, tw, th;
    int sxo, sxl, syo, syl, dxo, dxl, dyo, dyl;
    int rx, ry, px, py;
    longint s;
    d = '{default: '0};
    sw = clamp_side(img_src_w);
    sh = clamp_side(img_src_h);
    tw = clamp_side(img_dst_w);
    th = clamp_side(img_dst_h);
    if (r.req_type == REQ_START) begin
      rx = int'(r.rect_x);
      ry = int'(r.rect_y);
      px = int'(r.pos_x);
      py = int'(r.pos_y);
      clip_span(rx, int'(r.rect_w), sw, sxo, sxl);
      clip_span(ry, int'(r.rect_h), sh, syo, syl);
      clip_span(sxo - rx + px, sxl, tw, dxo, dxl);
      clip_span(syo - ry + py, syl, th, dyo, dyl);
      if (dxl == 0 || dyl == 0) begin
        walk_src = '0;
        walk_dst = '0;
        walk_width = '0;
        walk_rows_left = '0;
        return d;
      end
      s = longint'(img_src_base) + longint'(dyo - py + ry) * sw + (dxo - px + rx);
      walk_src = s[23:0];
      s = longint'(img_dst_base) + longint'(dyo) * tw + dxo;
      walk_dst = s[23:0];
      walk_width = dxl[DIM_W-1:0];
      walk_rows_left = dyl[DIM_W-1:0];
      d.src_addr = walk_src;
      d.dst_addr = walk_dst;
      d.row_len = walk_width;
      d.row_count = walk_rows_left;
      d.row_valid = 1'b1;
      return d;
    end
    if (walk_rows_left == 0) return d;
    d.src_addr = walk_src;
    d.dst_addr = walk_dst;
    d.row_len = walk_width;
    d.row_valid = 1'b1;
    d.last_row = (walk_rows_left == 1);
    walk_src = walk_src + 24'(sw);
    walk_dst = walk_dst + 24'(tw);
    walk_rows_left = walk_rows_left - 1'b1;
    return d;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    row_descr_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_rows.size() == 0) begin
        $error("result transfer with no request outstanding");
        error_count++;
      end else begin
        want = expected_rows.pop_front();
        check_field("src_addr", 32'(want.src_addr), 32'(src_addr));
        check_field("dst_addr", 32'(want.dst_addr), 32'(dst_addr));
        check_field("row_len", 32'(want.row_len), 32'(row_len));
        check_field("row_count", 32'(want.row_count), 32'(row_count));
        check_field("row_valid", 32'(want.row_valid), 32'(row_valid));
        check_field("last_row", 32'(want.last_row), 32'(last_row));
      end
    end
  end

  // receiver: random stalls, or a long hold-off when hold_left is loaded
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready = ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic apb_write(int unsigned idx, logic [31:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = APB_AW'(idx * 4);
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_SOURCE_WIDTH:  img_src_w = data[DIM_W-1:0];
      REG_SOURCE_HEIGHT: img_src_h = data[DIM_W-1:0];
      REG_TARGET_WIDTH:  img_dst_w = data[DIM_W-1:0];
      REG_TARGET_HEIGHT: img_dst_h = data[DIM_W-1:0];
      REG_SOURCE_BASE:   img_src_base = data[BASE_W-1:0];
      REG_TARGET_BASE:   img_dst_base = data[BASE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic send_request(blit_req_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    req_type = r.req_type;
    rect_x = r.rect_x;
    rect_y = r.rect_y;
    rect_w = r.rect_w;
    rect_h = r.rect_h;
    pos_x = r.pos_x;
    pos_y = r.pos_y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_rows.push_back(predict_descriptor(r));
  endtask

  // drop in_valid and wait until every outstanding result has been checked
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic blit_req_t start_req(int x, int y, int w, int h, int px, int py);
    blit_req_t r;
    r.req_type = REQ_START;
    r.rect_x = COORD_W'(x);
    r.rect_y = COORD_W'(y);
    r.rect_w = DIM_W'(w);
    r.rect_h = DIM_W'(h);
    r.pos_x = COORD_W'(px);
    r.pos_y = COORD_W'(py);
    return r;
  endfunction

  // rectangle fields are don't-care on a row request, so fill them with noise; the request type is random too
  function automatic blit_req_t noise_req();
    blit_req_t r;
    r = start_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    r.req_type = 1'($urandom_range(1));
    return r;
  endfunction

  function automatic blit_req_t row_req();
    blit_req_t r;
    r = noise_req();
    r.req_type = REQ_ROW;
    return r;
  endfunction

  function automatic blit_req_t random_start();
    int sw, sh, tw, th, w, h, x, y;
    sw = clamp_side(img_src_w);
    sh = clamp_side(img_src_h);
    tw = clamp_side(img_dst_w);
    th = clamp_side(img_dst_h);
    if ($urandom_range(99) < 10) begin
      return start_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
    w = $urandom_range(0, sw + 8);
    h = ($urandom_range(99) < 80) ? $urandom_range(0, 20) : $urandom_range(0, sh + 8);
    x = int'($urandom_range(0, sw + 16)) - 8;
    y = int'($urandom_range(0, sh + 16)) - 8;
    return start_req(x, y, w, h, int'($urandom_range(0, tw + w)) - w,
                     int'($urandom_range(0, th + h)) - h);
  endfunction

  task automatic send_start(int x, int y, int w, int h, int px, int py);
    send_request(start_req(x, y, w, h, px, py));
  endtask

  task automatic send_rows(int n);
    repeat (n) send_request(row_req());
  endtask

  function automatic int pick_side();
    case ($urandom_range(9))
      0:       return 1;
      1:       return MAX_SIDE;
      2, 3, 4: return $urandom_range(41, MAX_SIDE);
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  task automatic randomize_images();
    apb_write(REG_SOURCE_WIDTH, pick_side());
    apb_write(REG_SOURCE_HEIGHT, pick_side());
    apb_write(REG_TARGET_WIDTH, pick_side());
    apb_write(REG_TARGET_HEIGHT, pick_side());
    apb_write(REG_SOURCE_BASE, $urandom);
    apb_write(REG_TARGET_BASE, ($urandom_range(3) == 0) ? 32'h00FF_FFF0 : $urandom);
  endtask

  // well-formed blits with random content, some abandoned, some noise
  task automatic run_random_blits(int n_items);
    int sent;
    int plan;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 15) begin
        send_request(noise_req());
        sent++;
      end else begin
        send_request(random_start());
        sent++;
        if (walk_rows_left == 0) plan = $urandom_range(1);
        else if ($urandom_range(99) < 70) plan = int'(walk_rows_left) + $urandom_range(1);
        else plan = $urandom_range(0, int'(walk_rows_left) - 1);
        if (plan > 48) plan = 48;
        send_rows(plan);
        sent += plan;
      end
    end
  endtask

  task automatic test_directed_blits();
    send_rows(1);
    send_start(10, 5, 20, 3, 100, 50);
    send_rows(4);
    send_start(-5, -3, 10, 5, 0, 0);
    send_rows(1);
    send_start(300, 190, 50, 50, 310, 195);
    send_rows(2);
    send_start(10, 10, 0, 5, 10, 10);
    send_rows(1);
    send_start(2047, 2047, 2047, 2047, 2047, 2047);
    send_start(-2048, -2048, 2047, 2047, -2048, -2048);
    send_start(-1000, -1000, 2047, 2047, -1000, -1000);
    send_rows(2);
    send_start(0, 0, 0, 2047, 0, 0);
    send_start(5, 5, 8, 2, 2047, 2047);
    send_start(5, 5, 8, 2, -2048, -2048);
    send_rows(1);
    wait_idle();
  endtask

  task automatic test_image_edges();
    apb_write(REG_SOURCE_WIDTH, 1);
    apb_write(REG_SOURCE_HEIGHT, 1);
    apb_write(REG_TARGET_WIDTH, 1);
    apb_write(REG_TARGET_HEIGHT, 1);
    apb_write(REG_SOURCE_BASE, 32'hFFFF_FFFF);
    apb_write(REG_TARGET_BASE, 32'h00FF_FFFF);
    send_start(0, 0, 1, 1, 0, 0);
    send_rows(2);
    wait_idle();
    // oversized registers act as the maximum side; bases near the top wrap
    apb_write(REG_SOURCE_WIDTH, 2047);
    apb_write(REG_SOURCE_HEIGHT, 2047);
    apb_write(REG_TARGET_WIDTH, 1025);
    apb_write(REG_TARGET_HEIGHT, MAX_SIDE);
    apb_write(REG_SOURCE_BASE, 32'h00FF_FF00);
    apb_write(REG_TARGET_BASE, 32'h00FF_F000);
    send_start(0, 0, 2047, 2047, 0, 0);
    send_rows(3);
    send_start(1000, 1000, 100, 100, 1000, 1000);
    send_rows(25);
    wait_idle();
    // zero-sized image gives nothing to copy
    apb_write(REG_SOURCE_WIDTH, 0);
    send_start(0, 0, 10, 10, 0, 0);
    send_rows(1);
    wait_idle();
    apb_write(REG_SOURCE_WIDTH, 64);
    apb_write(UNUSED_REG_A, 32'h0000_0001);
    apb_write(UNUSED_REG_B, 32'hFFFF_FFFF);
    send_start(-3, 2, 70, 4, 5, -1);
    send_rows(4);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int idle_set[4] = '{0, 81, 0, 13};
    int stall_set[4] = '{0, 0, 81, 13};
    for (int p = 0; p < 4; p++) begin
      randomize_images();
      send_idle_pct = idle_set[p];
      stall_pct = stall_set[p];
      run_random_blits(270);
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    apb_write(REG_SOURCE_WIDTH, 40);
    apb_write(REG_SOURCE_HEIGHT, 40);
    apb_write(REG_TARGET_WIDTH, 40);
    apb_write(REG_TARGET_HEIGHT, 40);
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left = 300;
    send_start(2, 3, 30, 30, 5, 4);
    send_rows(40);
    send_start(-4, 20, 50, 30, -2, 30);
    send_rows(12);
    wait_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_blits();
    test_image_edges();
    test_random_traffic();
    test_backpressure();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: clipped_blit_row_address_generator.f
+incdir+hdl
hdl/cbrag_pkg.sv
hdl/cbrag_cfg.sv
hdl/cbrag_front.sv
hdl/cbrag_queue.sv
hdl/cbrag_back.sv
hdl/clipped_blit_row_address_generator.sv
tb/tb_top.sv
